### hdl/nefp_pkg.sv
// Shared types and constants of the nucleotide encoder and fingerprint block.
`default_nettype none
package nefp_pkg;

   localparam logic [63:0] FNV_BASIS      = 64'd14695981039346656037;
   // FNV-64 prime is 2^40 + 2^8 + 0xB3
   localparam logic [63:0] FNV_PRIME_LOW  = 64'h0000_0000_0000_00B3;
   localparam int          FNV_SHIFT_MID  = 8;
   localparam int          FNV_SHIFT_HIGH = 40;

   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] CHAR_A_LO = 8'h61;
   localparam logic [7:0] CHAR_C_UP = 8'h43;
   localparam logic [7:0] CHAR_C_LO = 8'h63;
   localparam logic [7:0] CHAR_G_UP = 8'h47;
   localparam logic [7:0] CHAR_G_LO = 8'h67;
   localparam logic [7:0] CHAR_T_UP = 8'h54;
   localparam logic [7:0] CHAR_T_LO = 8'h74;

   typedef enum logic [2:0] {
      CSR_ADENINE   = 3'd0,
      CSR_CYTOSINE  = 3'd1,
      CSR_GUANINE   = 3'd2,
      CSR_THYMINE   = 3'd3,
      CSR_AMBIGUOUS = 3'd4,
      CSR_BOUNDARY  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] adenine;
      logic [7:0] cytosine;
      logic [7:0] guanine;
      logic [7:0] thymine;
      logic [7:0] ambiguous;
      logic [7:0] boundary;
   } codes_type;

   // Classified character as it travels from front to back
   typedef struct packed {
      logic [7:0] code;
      logic       amb;
      logic       last;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_FETCH,
      ST_CHAR,
      ST_SEP_PREP,
      ST_SEP
   } back_state_type;

endpackage
`default_nettype wire

### hdl/nefp_if.sv
// Channel interfaces: character input, result output and register write port.
`default_nettype none
interface nefp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] base_char;
   logic       record_end;
   modport source (output valid, base_char, record_end, input ready);
   modport sink (input valid, base_char, record_end, output ready);
endinterface

interface nefp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  code_byte;
   logic        is_boundary;
   logic        was_ambiguous;
   logic [63:0] hash_value;
   logic [31:0] record_index;
   logic [63:0] record_offset;
   logic [63:0] record_size;
   logic [63:0] record_unclear;
   logic [63:0] sum_bases;
   logic [63:0] sum_unclear;
   logic        last_of_run;
   modport source (output valid, code_byte, is_boundary, was_ambiguous, hash_value,
                   record_index, record_offset, record_size, record_unclear,
                   sum_bases, sum_unclear, last_of_run, input ready);
   modport sink (input valid, code_byte, is_boundary, was_ambiguous, hash_value,
                 record_index, record_offset, record_size, record_unclear,
                 sum_bases, sum_unclear, last_of_run, output ready);
endinterface

interface nefp_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/nefp_front.sv
// Front end: accepts characters and maps them to code bytes and ambiguity flags.
`default_nettype none
module nefp_front (
   nefp_req_if.sink                  req_bus,
   input  nefp_pkg::codes_type        codes,
   input  nefp_pkg::queue_status_type q_status,
   output logic                      push,
   output nefp_pkg::item_type         push_item
);
   import nefp_pkg::*;

   assign req_bus.ready = !q_status.full;
   assign push          = req_bus.valid && !q_status.full;

   always_comb begin
      push_item.last = req_bus.record_end;
      push_item.amb  = 1'b0;
      unique case (req_bus.base_char) inside
         CHAR_A_UP, CHAR_A_LO: push_item.code = codes.adenine;
         CHAR_C_UP, CHAR_C_LO: push_item.code = codes.cytosine;
         CHAR_G_UP, CHAR_G_LO: push_item.code = codes.guanine;
         CHAR_T_UP, CHAR_T_LO: push_item.code = codes.thymine;
         default: begin
            push_item.code = codes.ambiguous;
            push_item.amb  = 1'b1;
         end
      endcase
   end
endmodule
`default_nettype wire

### hdl/nefp_queue.sv
// Short FIFO of classified characters between front and back.
`default_nettype none
module nefp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  nefp_pkg::item_type             push_item,
   input  logic                          pop,
   output nefp_pkg::item_type             head_item,
   output nefp_pkg::queue_status_type     status,
   output logic [$clog2(DEPTH+1)-1:0]    count
);
   import nefp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = mem_ff[rd_ptr_ff];
   assign count        = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

### hdl/nefp_back.sv
// Back end: folds code bytes into the FNV-1a hash, keeps record counters, drives results.
`default_nettype none
module nefp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  nefp_pkg::codes_type            codes,
   input  nefp_pkg::queue_status_type     q_status,
   input  nefp_pkg::item_type             head_item,
   output logic                          pop,
   nefp_rsp_if.source                    rsp_bus
);
   import nefp_pkg::*;

   back_state_type state_ff, state_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] mix_ff, mix_in;
   logic [63:0] prod_ff, prod_in;
   item_type    cur_ff, cur_in;
   logic [63:0] start_ff, start_in;
   logic [63:0] length_ff, length_in;
   logic [63:0] unclear_ff, unclear_in;
   logic [31:0] records_ff, records_in;
   logic [63:0] tot_bases_ff, tot_bases_in;
   logic [63:0] tot_unclear_ff, tot_unclear_in;

   logic        rv_ff, rv_in;
   logic [7:0]  r_code_ff, r_code_in;
   logic        r_bound_ff, r_bound_in;
   logic        r_amb_ff, r_amb_in;
   logic [63:0] r_hash_ff, r_hash_in;
   logic [31:0] r_index_ff, r_index_in;
   logic [63:0] r_offset_ff, r_offset_in;
   logic [63:0] r_size_ff, r_size_in;
   logic [63:0] r_unclear_ff, r_unclear_in;
   logic [63:0] r_sum_b_ff, r_sum_b_in;
   logic [63:0] r_sum_u_ff, r_sum_u_in;
   logic        r_last_ff, r_last_in;

   logic        out_free;
   logic [7:0]  fold_byte;
   logic [63:0] fold_src;
   logic [63:0] hash_mix;

   assign out_free  = !rv_ff || rsp_bus.ready;
   assign fold_byte = (state_ff == ST_SEP_PREP) ? codes.boundary : head_item.code;
   assign fold_src  = hash_ff ^ {56'd0, fold_byte};
   // second half of the multiply by the sparse prime
   assign hash_mix  = prod_ff + (mix_ff << FNV_SHIFT_MID) + (mix_ff << FNV_SHIFT_HIGH);

   always_comb begin
      state_in       = state_ff;
      hash_in        = hash_ff;
      mix_in         = mix_ff;
      prod_in        = prod_ff;
      cur_in         = cur_ff;
      start_in       = start_ff;
      length_in      = length_ff;
      unclear_in     = unclear_ff;
      records_in     = records_ff;
      tot_bases_in   = tot_bases_ff;
      tot_unclear_in = tot_unclear_ff;
      rv_in          = rv_ff && !rsp_bus.ready;
      r_code_in      = r_code_ff;
      r_bound_in     = r_bound_ff;
      r_amb_in       = r_amb_ff;
      r_hash_in      = r_hash_ff;
      r_index_in     = r_index_ff;
      r_offset_in    = r_offset_ff;
      r_size_in      = r_size_ff;
      r_unclear_in   = r_unclear_ff;
      r_sum_b_in     = r_sum_b_ff;
      r_sum_u_in     = r_sum_u_ff;
      r_last_in      = r_last_ff;
      pop            = 1'b0;

      unique case (state_ff)
         ST_FETCH: begin
            if (!q_status.empty) begin
               pop       = 1'b1;
               mix_in    = fold_src;
               prod_in   = fold_src * FNV_PRIME_LOW;
               cur_in    = head_item;
               length_in = length_ff + 64'd1;
               if (head_item.amb) begin
                  unclear_in = unclear_ff + 64'd1;
               end
               state_in  = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (out_free) begin
               hash_in      = hash_mix;
               rv_in        = 1'b1;
               r_code_in    = cur_ff.code;
               r_bound_in   = 1'b0;
               r_amb_in     = cur_ff.amb;
               r_hash_in    = hash_mix;
               r_index_in   = '0;
               r_offset_in  = '0;
               r_size_in    = '0;
               r_unclear_in = '0;
               r_sum_b_in   = tot_bases_ff;
               r_sum_u_in   = tot_unclear_ff;
               r_last_in    = !cur_ff.last;
               state_in     = cur_ff.last ? ST_SEP_PREP : ST_FETCH;
            end
         end
         ST_SEP_PREP: begin
            mix_in         = fold_src;
            prod_in        = fold_src * FNV_PRIME_LOW;
            tot_bases_in   = tot_bases_ff + length_ff;
            tot_unclear_in = tot_unclear_ff + unclear_ff;
            state_in       = ST_SEP;
         end
         ST_SEP: begin
            if (out_free) begin
               hash_in      = hash_mix;
               rv_in        = 1'b1;
               r_code_in    = codes.boundary;
               r_bound_in   = 1'b1;
               r_amb_in     = 1'b0;
               r_hash_in    = hash_mix;
               r_index_in   = records_ff;
               r_offset_in  = start_ff;
               r_size_in    = length_ff;
               r_unclear_in = unclear_ff;
               r_sum_b_in   = tot_bases_ff;
               r_sum_u_in   = tot_unclear_ff;
               r_last_in    = 1'b1;
               // next record starts one past the separator
               start_in     = start_ff + length_ff + 64'd1;
               length_in    = '0;
               unclear_in   = '0;
               records_in   = records_ff + 32'd1;
               state_in     = ST_FETCH;
            end
         end
         default: state_in = ST_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_FETCH;
         hash_ff        <= FNV_BASIS;
         start_ff       <= '0;
         length_ff      <= '0;
         unclear_ff     <= '0;
         records_ff     <= '0;
         tot_bases_ff   <= '0;
         tot_unclear_ff <= '0;
         rv_ff          <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hash_ff        <= hash_in;
         start_ff       <= start_in;
         length_ff      <= length_in;
         unclear_ff     <= unclear_in;
         records_ff     <= records_in;
         tot_bases_ff   <= tot_bases_in;
         tot_unclear_ff <= tot_unclear_in;
         rv_ff          <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff       <= mix_in;
      prod_ff      <= prod_in;
      cur_ff       <= cur_in;
      r_code_ff    <= r_code_in;
      r_bound_ff   <= r_bound_in;
      r_amb_ff     <= r_amb_in;
      r_hash_ff    <= r_hash_in;
      r_index_ff   <= r_index_in;
      r_offset_ff  <= r_offset_in;
      r_size_ff    <= r_size_in;
      r_unclear_ff <= r_unclear_in;
      r_sum_b_ff   <= r_sum_b_in;
      r_sum_u_ff   <= r_sum_u_in;
      r_last_ff    <= r_last_in;
   end

   assign rsp_bus.valid          = rv_ff;
   assign rsp_bus.code_byte      = r_code_ff;
   assign rsp_bus.is_boundary    = r_bound_ff;
   assign rsp_bus.was_ambiguous  = r_amb_ff;
   assign rsp_bus.hash_value     = r_hash_ff;
   assign rsp_bus.record_index   = r_index_ff;
   assign rsp_bus.record_offset  = r_offset_ff;
   assign rsp_bus.record_size    = r_size_ff;
   assign rsp_bus.record_unclear = r_unclear_ff;
   assign rsp_bus.sum_bases      = r_sum_b_ff;
   assign rsp_bus.sum_unclear    = r_sum_u_ff;
   assign rsp_bus.last_of_run    = r_last_ff;
endmodule
`default_nettype wire

### hdl/nucleotide_encode_fingerprint_top.sv
// A character's result goes through the queue, fold registers and result registers in turn.
// The back end finishes one character (fetch, then result step) before it fetches the next;
//   a record's end adds the separator. The FNV fold: multiply by 0xB3, then a three-term add.
// A queue of QUEUE_DEPTH entries lets the front accept beats while the back works.
// Reset is synchronous: hash returns to the FNV offset basis, counters clear, codes take
//   their defaults 0..5; no clearing pass.
`default_nettype none
module nucleotide_encode_fingerprint_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   nefp_req_if.sink     req_bus,
   nefp_rsp_if.source   rsp_bus,
   nefp_csr_if.sink     csr_bus
);
   import nefp_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   codes_type        codes_ff, codes_in;
   queue_status_type q_status;
   item_type         push_item;
   item_type         head_item;
   logic             push;
   logic             pop;
   logic [CW-1:0]    q_count;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      codes_in = codes_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ADENINE:   codes_in.adenine   = csr_bus.data;
            CSR_CYTOSINE:  codes_in.cytosine  = csr_bus.data;
            CSR_GUANINE:   codes_in.guanine   = csr_bus.data;
            CSR_THYMINE:   codes_in.thymine   = csr_bus.data;
            CSR_AMBIGUOUS: codes_in.ambiguous = csr_bus.data;
            CSR_BOUNDARY:  codes_in.boundary  = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= '{adenine: 8'd0, cytosine: 8'd1, guanine: 8'd2,
                       thymine: 8'd3, ambiguous: 8'd4, boundary: 8'd5};
      end else begin
         codes_ff <= codes_in;
      end
   end

   nefp_front u_front (
      .req_bus   (req_bus),
      .codes     (codes_ff),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   nefp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status),
      .count     (q_count)
   );

   nefp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .codes     (codes_ff),
      .q_status  (q_status),
      .head_item (head_item),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTHESIS
   a_sep_not_amb: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_boundary |-> !rsp_bus.was_ambiguous && rsp_bus.last_of_run)
      else $error("separator beat flagged ambiguous or not last");

   a_char_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.is_boundary |->
         rsp_bus.record_size == 64'd0 && rsp_bus.record_index == 32'd0)
      else $error("character beat carries record fields");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CW'(QUEUE_DEPTH) && (q_status.full == (q_count == CW'(QUEUE_DEPTH))))
      else $error("queue count out of range");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !req_bus.ready)
      else $error("input accepted while queue full");
`endif
endmodule
`default_nettype wire

### bench/nefp_fingerprint_checker.sv
// Checker for the nucleotide encoder: predicts code beats and fingerprints, compares results.
`timescale 1ns / 1ps
module nefp_fingerprint_checker (
   input  logic  clock,
   input  logic  reset,
   nefp_req_if   req_mon,
   nefp_rsp_if   rsp_mon,
   nefp_csr_if   csr_mon,
   output int    mismatch_count,
   output int    pending_count
);
   import nefp_pkg::*;

   localparam logic [63:0] FNV64_PRIME = 64'd1099511628211;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic        is_boundary;
      logic        was_ambiguous;
      logic [63:0] hash_value;
      logic [31:0] record_index;
      logic [63:0] record_offset;
      logic [63:0] record_size;
      logic [63:0] record_unclear;
      logic [63:0] sum_bases;
      logic [63:0] sum_unclear;
      logic        last_of_run;
   } code_beat_type;

   code_beat_type predicted_beats [$];
   codes_type     code_map;
   logic [63:0]   fingerprint;
   logic [63:0]   next_origin;
   logic [63:0]   rec_origin;
   logic [63:0]   rec_len;
   logic [63:0]   rec_unclear;
   logic [31:0]   rec_count;
   logic [63:0]   bases_total;
   logic [63:0]   unclear_total;
   int            errs = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV64_PRIME;
   endfunction

   task automatic clear_model();
      code_map      = '{adenine: 8'd0, cytosine: 8'd1, guanine: 8'd2, thymine: 8'd3,
                        ambiguous: 8'd4, boundary: 8'd5};
      fingerprint   = FNV_BASIS;
      next_origin   = '0;
      rec_origin    = '0;
      rec_len       = '0;
      rec_unclear   = '0;
      rec_count     = '0;
      bases_total   = '0;
      unclear_total = '0;
      predicted_beats.delete();
   endtask

   task automatic encode_char(input logic [7:0] ch, input logic fin);
      code_beat_type beat;
      logic [7:0]    code;
      logic          unclear;
      unclear = 1'b0;
      case (ch)
         CHAR_A_UP, CHAR_A_LO: code = code_map.adenine;
         CHAR_C_UP, CHAR_C_LO: code = code_map.cytosine;
         CHAR_G_UP, CHAR_G_LO: code = code_map.guanine;
         CHAR_T_UP, CHAR_T_LO: code = code_map.thymine;
         default: begin
            code    = code_map.ambiguous;
            unclear = 1'b1;
         end
      endcase
      if (rec_len == 64'd0)
         rec_origin = next_origin;
      fingerprint = fnv_fold(fingerprint, code);
      rec_len     = rec_len + 64'd1;
      if (unclear)
         rec_unclear = rec_unclear + 64'd1;

      beat               = '0;
      beat.code_byte     = code;
      beat.was_ambiguous = unclear;
      beat.hash_value    = fingerprint;
      beat.sum_bases     = bases_total;
      beat.sum_unclear   = unclear_total;
      beat.last_of_run   = !fin;
      predicted_beats    = {predicted_beats, beat};
      if (!fin)
         return;

      // separator beat closes the record
      fingerprint   = fnv_fold(fingerprint, code_map.boundary);
      bases_total   = bases_total + rec_len;
      unclear_total = unclear_total + rec_unclear;
      next_origin   = rec_origin + rec_len + 64'd1;

      beat                = '0;
      beat.code_byte      = code_map.boundary;
      beat.is_boundary    = 1'b1;
      beat.hash_value     = fingerprint;
      beat.record_index   = rec_count;
      beat.record_offset  = rec_origin;
      beat.record_size    = rec_len;
      beat.record_unclear = rec_unclear;
      beat.sum_bases      = bases_total;
      beat.sum_unclear    = unclear_total;
      beat.last_of_run    = 1'b1;
      predicted_beats     = {predicted_beats, beat};

      rec_count   = rec_count + 32'd1;
      rec_len     = '0;
      rec_unclear = '0;
      rec_origin  = next_origin;
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errs++;
         $display("%0t %s: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      code_beat_type want;
      if (reset) begin
         clear_model();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ADENINE:   code_map.adenine   = csr_mon.data;
               CSR_CYTOSINE:  code_map.cytosine  = csr_mon.data;
               CSR_GUANINE:   code_map.guanine   = csr_mon.data;
               CSR_THYMINE:   code_map.thymine   = csr_mon.data;
               CSR_AMBIGUOUS: code_map.ambiguous = csr_mon.data;
               CSR_BOUNDARY:  code_map.boundary  = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            encode_char(req_mon.base_char, req_mon.record_end);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_beats.size() == 0) begin
               errs++;
               $display("%0t unexpected result beat: expected none, actual code %0h hash %0h",
                        $time, rsp_mon.code_byte, rsp_mon.hash_value);
            end else begin
               want = predicted_beats.pop_front();
               check_field("code_byte", 64'(want.code_byte), 64'(rsp_mon.code_byte));
               check_field("is_boundary", 64'(want.is_boundary), 64'(rsp_mon.is_boundary));
               check_field("was_ambiguous", 64'(want.was_ambiguous),
                           64'(rsp_mon.was_ambiguous));
               check_field("hash_value", want.hash_value, rsp_mon.hash_value);
               check_field("record_index", 64'(want.record_index),
                           64'(rsp_mon.record_index));
               check_field("record_offset", want.record_offset, rsp_mon.record_offset);
               check_field("record_size", want.record_size, rsp_mon.record_size);
               check_field("record_unclear", want.record_unclear, rsp_mon.record_unclear);
               check_field("sum_bases", want.sum_bases, rsp_mon.sum_bases);
               check_field("sum_unclear", want.sum_unclear, rsp_mon.sum_unclear);
               check_field("last_of_run", 64'(want.last_of_run), 64'(rsp_mon.last_of_run));
            end
         end
      end
      mismatch_count <= errs;
      pending_count  <= predicted_beats.size();
   end

endmodule

### bench/nucleotide_encode_fingerprint_top_test.sv
// Top of the nucleotide encoder test: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module nucleotide_encode_fingerprint_top_test;
   import nefp_pkg::*;

   localparam int         PHASE_COUNT    = 8;
   localparam int         PHASE_ITEMS    = 250;
   localparam int         IDLE_PCT       = 29;
   localparam int         HOLD_OFF       = 150;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam logic [2:0] CSR_SPARE_LO   = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI   = 3'd7;

   // {record_end, base_char}
   localparam logic [8:0] DIRECTED_BEATS [20] = '{
      {1'b0, CHAR_A_UP}, {1'b0, CHAR_A_LO}, {1'b0, CHAR_C_UP}, {1'b0, CHAR_C_LO},
      {1'b0, CHAR_G_UP}, {1'b0, CHAR_G_LO}, {1'b0, CHAR_T_UP}, {1'b1, CHAR_T_LO},
      {1'b1, 8'h4E},     {1'b0, 8'h00},     {1'b0, 8'hFF},     {1'b0, 8'h6E},
      {1'b0, 8'h55},     {1'b1, 8'h40},     {1'b0, 8'h42},     {1'b0, 8'h80},
      {1'b1, 8'h7F},     {1'b1, CHAR_G_UP}, {1'b0, 8'h5A},     {1'b1, CHAR_C_LO}
   };

   logic clock = 1'b0;
   logic reset;
   int   req_idle_pct    = IDLE_PCT;
   int   rsp_idle_pct    = IDLE_PCT;
   int   rsp_hold_cycles = 0;
   int   items_sent      = 0;
   int   records_sent    = 0;
   int   stall_cycles    = 0;
   int   mismatch_count;
   int   pending_count;

   nefp_req_if req_bus ();
   nefp_rsp_if rsp_bus ();
   nefp_csr_if csr_bus ();

   nucleotide_encode_fingerprint_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   nefp_fingerprint_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random idling, plus a counted hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic csr_put(input logic [2:0] idx, input logic [7:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic program_codes(input logic [7:0] a, c, g, t, n, b);
      csr_put(CSR_ADENINE, a);
      csr_put(CSR_CYTOSINE, c);
      csr_put(CSR_GUANINE, g);
      csr_put(CSR_THYMINE, t);
      csr_put(CSR_AMBIGUOUS, n);
      csr_put(CSR_BOUNDARY, b);
      // spare indexes must be ignored
      csr_put(CSR_SPARE_LO, 8'($urandom_range(0, 255)));
      csr_put(CSR_SPARE_HI, 8'($urandom_range(0, 255)));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_base(input logic [7:0] ch, input logic fin);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.base_char  <= ch;
      req_bus.record_end <= fin;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (fin)
         records_sent++;
   endtask

   function automatic logic [7:0] random_char();
      logic [7:0] bases [8];
      bases = '{CHAR_A_UP, CHAR_A_LO, CHAR_C_UP, CHAR_C_LO,
                CHAR_G_UP, CHAR_G_LO, CHAR_T_UP, CHAR_T_LO};
      if ($urandom_range(0, 9) < 8)
         return bases[$urandom_range(0, 7)];
      return 8'($urandom_range(0, 255));
   endfunction

   // hold the sender until every predicted beat has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      int         phase_items;
      int         len;
      logic [7:0] same_code;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.base_char  <= '0;
      req_bus.record_end <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: ;
            1: program_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            2: program_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            3: begin
               // coinciding codes must not disturb the ambiguous counts
               same_code = 8'($urandom_range(0, 255));
               program_codes(same_code, same_code, same_code, same_code, same_code,
                             same_code);
            end
            6: program_codes(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
            default: program_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         req_idle_pct = (phase == 5) ? 0 : IDLE_PCT;
         rsp_idle_pct = (phase == 5) ? 0 : IDLE_PCT;
         if (phase == 2)
            rsp_hold_cycles = HOLD_OFF;
         phase_items = 0;
         if (phase == 0) begin
            foreach (DIRECTED_BEATS[k])
               send_base(DIRECTED_BEATS[k][7:0], DIRECTED_BEATS[k][8]);
         end
         while (phase_items < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 16);
            for (int k = 0; k < len; k++)
               send_base(random_char(), k == len - 1);
            phase_items += len;
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      $display("covered %0d characters in %0d records over %0d code settings",
               items_sent, records_sent, PHASE_COUNT);
      $display("settings: defaults, all zero, all ones, coinciding, mixed extremes, random");
      if (mismatch_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
hdl/nefp_pkg.sv
hdl/nefp_if.sv
hdl/nefp_front.sv
hdl/nefp_queue.sv
hdl/nefp_back.sv
hdl/nucleotide_encode_fingerprint_top.sv
bench/nefp_fingerprint_checker.sv
bench/nucleotide_encode_fingerprint_top_test.sv
